[hw/rtl/mes_pkg.sv]
// Package for the minute event scheduler: shared constants, codes and the
// control/status structs between controller and datapath. No dependencies.
package mes_pkg;

  localparam int MIN_W = 11;            // minute-of-day and dividend width
  localparam int REM_W = 12;            // divisor and remainder width
  localparam int MINUTES_PER_DAY = 1440;
  localparam int SYNC_MINUTE = 480;
  localparam int UPLOAD_WINDOW = 3;
  localparam int SUPPRESS_TICKS = 5 - 1;
  localparam int UPLOAD_RETRY_MIN = 30;
  localparam int DEFAULT_CYCLE = 60;
  localparam int MON_RETRY_STEP = 10;

  // request kinds carried on in_tuser
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_LOAD     = 2'd1;
  localparam logic [1:0] REQ_RESTART  = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_WARN_EN   = 3'd0;
  localparam logic [2:0] CFG_WARN_INT  = 3'd1;
  localparam logic [2:0] CFG_MON_EN    = 3'd2;
  localparam logic [2:0] CFG_MON_INT   = 3'd3;
  localparam logic [2:0] CFG_UPLOAD_EN = 3'd4;
  localparam logic [2:0] CFG_SYNC_EN   = 3'd5;

  // remainder operations run on the shared divider
  localparam logic [2:0] OP_WARN = 3'd0;
  localparam logic [2:0] OP_MON  = 3'd1;
  localparam logic [2:0] OP_PER  = 3'd3;
  localparam logic [2:0] OP_OFS  = 3'd4;

  typedef struct packed {
    logic [7:0]  period;
    logic [2:0]  wday;
    logic [11:0] offset;
  } entry_t;

  typedef struct packed {
    logic       accept;
    logic       start;
    logic       capture;
    logic [2:0] op;
    logic       pre;
    logic       ent_init;
    logic       eval;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic req_tick;
    logic mod_done;
    logic scan_go;
    logic idx_done;
    logic ent_skip;
    logic ent_per;
    logic ent_neg;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/mes_div.sv]
// Shared remainder unit: restoring division, one quotient bit per cycle.
// Depends on mes_pkg for widths.
module mes_div
  import mes_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MIN_W-1:0] dividend,
  input  logic [REM_W-1:0] divisor,
  output logic             done,
  output logic [REM_W-1:0] rem
);

  localparam logic [3:0] LAST = 4'(MIN_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [MIN_W-1:0] dvd_r, dvd_nxt;
  logic [REM_W-1:0] trial;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r[REM_W-2:0], dvd_r[MIN_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = (trial >= divisor) ? trial - divisor : trial;
      dvd_nxt = {dvd_r[MIN_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[hw/rtl/mes_dp.sv]
// Datapath: configuration, schedule table, counters, result register.
// Depends on mes_pkg and mes_div.
module mes_dp
  import mes_pkg::*;
#(
  parameter int SCHEDULE_ENTRIES = 9,
  parameter int IW = 4,
  parameter int CW = 4
)(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [10:0]   cfg_data,
  input  logic [47:0]   in_tdata,
  input  logic [1:0]    in_tuser,
  input  cmd_t          cmd,
  input  logic [CW-1:0] ent_cnt,
  input  logic          out_tready,
  output sts_t          sts,
  output logic          out_tvalid,
  output logic [7:0]    out_tdata
);

  // configuration
  logic        warn_en_r, mon_en_r, up_en_r, sync_en_r;
  logic [10:0] warn_int_r, mon_int_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warn_en_r  <= 1'b0;
      mon_en_r   <= 1'b0;
      up_en_r    <= 1'b0;
      sync_en_r  <= 1'b0;
      warn_int_r <= '0;
      mon_int_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WARN_EN:   warn_en_r  <= cfg_data[0];
        CFG_WARN_INT:  warn_int_r <= cfg_data;
        CFG_MON_EN:    mon_en_r   <= cfg_data[0];
        CFG_MON_INT:   mon_int_r  <= cfg_data;
        CFG_UPLOAD_EN: up_en_r    <= cfg_data[0];
        CFG_SYNC_EN:   sync_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input item fields
  logic [4:0]  f_hour;
  logic [5:0]  f_minute;
  logic [2:0]  f_wday;
  logic [3:0]  f_idx;
  entry_t      f_entry;
  assign f_hour   = in_tdata[4:0];
  assign f_minute = in_tdata[10:5];
  assign f_wday   = in_tdata[13:11];
  assign f_idx    = in_tdata[20:17];
  assign f_entry  = '{period: in_tdata[28:21], wday: in_tdata[31:29],
                      offset: in_tdata[43:32]};

  logic [4:0] hour_r;
  logic [5:0] minute_r;
  logic [2:0] wday_r;
  logic       clkv_r, mretry_r, uretry_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hour_r   <= f_hour;
      minute_r <= f_minute;
      wday_r   <= f_wday;
      clkv_r   <= in_tdata[14];
      mretry_r <= in_tdata[15];
      uretry_r <= in_tdata[16];
    end
  end

  // schedule table; period zero marks a disabled entry
  entry_t table_r [SCHEDULE_ENTRIES];
  logic   load_ok;
  assign load_ok = cmd.accept && (in_tuser == REQ_LOAD) &&
                   ({1'b0, f_idx} < 5'(SCHEDULE_ENTRIES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SCHEDULE_ENTRIES; i++) table_r[i].period <= '0;
    end else if (load_ok) begin
      table_r[f_idx[IW-1:0]] <= f_entry;
    end
  end

  // current entry under scan
  entry_t      ent;
  logic [11:0] negm;
  logic [CW-1:0] lim;
  assign ent  = table_r[ent_cnt[IW-1:0]];
  assign negm = ~ent.offset + 12'd1;
  assign lim  = (table_r[0].period != '0) ? CW'(1) : CW'(SCHEDULE_ENTRIES);

  // effective warning period
  logic [10:0] wi;
  assign wi = (warn_en_r && mon_en_r && (mon_int_r < warn_int_r)) ? mon_int_r : warn_int_r;

  // state registers
  logic [10:0] mc_r, mc_nxt;
  logic [2:0]  supp_r, supp_nxt;
  logic        ridle_r, ridle_nxt;
  logic [4:0]  rcnt_r, rcnt_nxt;
  logic        tick_r, tick_nxt;
  logic        wz_r, wz_nxt, mz_r, mz_nxt;
  logic        upev_r, upev_nxt, clru_r, clru_nxt;
  logic [10:0] dval_r, dval_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  od_r, od_nxt;

  // minute counter modulo 10 by reciprocal multiply, exact below 2048
  logic [23:0] ten_prod;
  logic [10:0] ten_q10;
  logic        tz;
  assign ten_prod = {13'd0, mc_r} * 24'd6554;
  assign ten_q10  = {3'd0, ten_prod[23:16]} * 11'(MON_RETRY_STEP);
  assign tz       = (mc_r == ten_q10);

  // shared divider operand select
  logic [MIN_W-1:0] dvd;
  logic [REM_W-1:0] dvs, rem;
  logic             mdone;

  always_comb begin
    dvd = mc_r;
    dvs = {1'b0, wi};
    unique case (cmd.op)
      OP_WARN: begin dvd = mc_r;   dvs = {1'b0, wi};        end
      OP_MON:  begin dvd = mc_r;   dvs = {1'b0, mon_int_r}; end
      OP_PER:  begin dvd = dval_r; dvs = {4'd0, ent.period}; end
      OP_OFS:  begin dvd = dval_r; dvs = negm;              end
      default: begin dvd = mc_r;   dvs = {1'b0, wi};        end
    endcase
  end

  mes_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (mdone),
    .rem      (rem)
  );

  // entry match
  logic signed [12:0] diff;
  logic               hit, cyc_long;
  assign diff     = $signed({2'b00, dval_r}) - $signed({ent.offset[11], ent.offset});
  assign hit      = ent.offset[11] ? (dval_r < 11'(UPLOAD_WINDOW))
                                   : (!diff[12] && (diff < 13'sd3));
  assign cyc_long = ent.offset[11] ? (negm >= 12'(DEFAULT_CYCLE)) : 1'b1;

  // tick results
  logic        w_ev, m_ev, clr_m, kick, wrap, scan_run, rfire;
  logic [11:0] mc_inc;
  logic [4:0]  rdec;
  assign w_ev   = tick_r && warn_en_r && (wi != '0) && wz_r;
  assign clr_m  = tick_r && mon_en_r && (mon_int_r != '0) && mz_r;
  assign m_ev   = clr_m || (tick_r && mon_en_r && tz && mretry_r);
  assign mc_inc = {1'b0, mc_r} + 12'd1;
  assign kick   = tick_r && sync_en_r && (mc_inc == 12'(SYNC_MINUTE));
  assign wrap   = tick_r && (mc_inc >= 12'(MINUTES_PER_DAY));
  assign scan_run = up_en_r && (supp_r == '0);
  assign rdec   = (!ridle_r && rcnt_r != '0) ? rcnt_r - 5'd1 : rcnt_r;
  assign rfire  = scan_run && !ridle_r && (rdec == '0) && uretry_r;

  always_comb begin
    mc_nxt    = mc_r;
    supp_nxt  = supp_r;
    ridle_nxt = ridle_r;
    rcnt_nxt  = rcnt_r;
    tick_nxt  = tick_r;
    wz_nxt    = wz_r;
    mz_nxt    = mz_r;
    upev_nxt  = upev_r;
    clru_nxt  = clru_r;
    dval_nxt  = dval_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    // item accepted: clear flags, apply restart
    if (cmd.accept) begin
      tick_nxt = (in_tuser == REQ_TICK);
      wz_nxt   = 1'b0;
      mz_nxt   = 1'b0;
      upev_nxt = 1'b0;
      clru_nxt = 1'b0;
      if (in_tuser == REQ_RESTART) mc_nxt = '0;
    end
    // divider result
    if (cmd.capture) begin
      unique case (cmd.op)
        OP_WARN: wz_nxt = (rem == '0);
        OP_MON:  mz_nxt = (rem == '0);
        default: dval_nxt = rem[10:0];
      endcase
    end
    // retry timer step and suppress countdown
    if (cmd.pre) begin
      rcnt_nxt = rdec;
      if (rfire) begin
        upev_nxt  = 1'b1;
        ridle_nxt = 1'b1;
      end
      if (!scan_run && supp_r != '0) supp_nxt = supp_r - 3'd1;
    end
    if (cmd.ent_init) dval_nxt = 11'(hour_r) * 11'd60 + 11'(minute_r);
    // matching entry
    if (cmd.eval && hit) begin
      upev_nxt = 1'b1;
      clru_nxt = 1'b1;
      supp_nxt = 3'(SUPPRESS_TICKS);
      if (cyc_long) begin
        ridle_nxt = 1'b0;
        rcnt_nxt  = 5'(UPLOAD_RETRY_MIN);
      end else begin
        ridle_nxt = 1'b1;
      end
    end
    // result out, minute counter advance
    if (cmd.finish) begin
      ov_nxt = 1'b1;
      od_nxt = {1'b0, wrap, kick, clru_r, clr_m, upev_r, m_ev, w_ev};
      if (tick_r) mc_nxt = wrap ? '0 : mc_inc[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_r    <= '0;
      supp_r  <= '0;
      ridle_r <= 1'b1;
      rcnt_r  <= '0;
      ov_r    <= 1'b0;
      tick_r  <= 1'b0;
    end else begin
      mc_r    <= mc_nxt;
      supp_r  <= supp_nxt;
      ridle_r <= ridle_nxt;
      rcnt_r  <= rcnt_nxt;
      ov_r    <= ov_nxt;
      tick_r  <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wz_r   <= wz_nxt;
    mz_r   <= mz_nxt;
    upev_r <= upev_nxt;
    clru_r <= clru_nxt;
    dval_r <= dval_nxt;
    od_r   <= od_nxt;
  end

  // status to controller
  assign sts.req_tick = (in_tuser == REQ_TICK);
  assign sts.mod_done = mdone;
  assign sts.scan_go  = scan_run && clkv_r;
  assign sts.idx_done = (ent_cnt >= lim);
  assign sts.ent_skip = (ent.period == '0) ||
                        !((ent.wday == '0) || ({1'b0, ent.wday} == {1'b0, wday_r} + 4'd1));
  assign sts.ent_per  = (ent.period > 8'd1);
  assign sts.ent_neg  = ent.offset[11];
  assign sts.hit      = hit;
  assign sts.out_free = !ov_r || out_tready;

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

`ifndef ASSERT_OFF
  a_supp_range: assert property (@(posedge clk) disable iff (!rst_n)
    supp_r <= 3'(SUPPRESS_TICKS))
    else $error("suppress count out of range");
  a_retry_range: assert property (@(posedge clk) disable iff (!rst_n)
    !ridle_r |-> rcnt_r <= 5'(UPLOAD_RETRY_MIN))
    else $error("retry timer out of range");
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> ov_r)
    else $error("finished item not presented");
`endif

endmodule

[hw/rtl/mes_ctrl.sv]
// Controller: sequences the remainder operations and the entry scan.
// Depends on mes_pkg.
module mes_ctrl
  import mes_pkg::*;
#(
  parameter int CW = 4
)(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  sts_t          sts,
  output cmd_t          cmd,
  output logic [CW-1:0] ent_cnt
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MSTART = 3'd1;
  localparam logic [2:0] S_MWAIT  = 3'd2;
  localparam logic [2:0] S_PRE    = 3'd3;
  localparam logic [2:0] S_ENT    = 3'd4;
  localparam logic [2:0] S_EVAL   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = op_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.req_tick) begin
            op_nxt    = OP_WARN;
            state_nxt = S_MSTART;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_MSTART: begin
        cmd.start = 1'b1;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.mod_done) begin
          cmd.capture = 1'b1;
          unique case (op_r)
            OP_WARN: begin op_nxt = OP_MON; state_nxt = S_MSTART; end
            OP_MON:  state_nxt = S_PRE;
            OP_PER: begin
              if (sts.ent_neg) begin
                op_nxt    = OP_OFS;
                state_nxt = S_MSTART;
              end else begin
                state_nxt = S_EVAL;
              end
            end
            default: state_nxt = S_EVAL;
          endcase
        end
      end
      S_PRE: begin
        cmd.pre = 1'b1;
        cnt_nxt = '0;
        state_nxt = sts.scan_go ? S_ENT : S_FIN;
      end
      // walk the table, skipping entries that do not take part
      S_ENT: begin
        cmd.ent_init = 1'b1;
        priority if (sts.idx_done) begin
          state_nxt = S_FIN;
        end else if (sts.ent_skip) begin
          cnt_nxt = cnt_r + CW'(1);
        end else if (sts.ent_per) begin
          op_nxt    = OP_PER;
          state_nxt = S_MSTART;
        end else if (sts.ent_neg) begin
          op_nxt    = OP_OFS;
          state_nxt = S_MSTART;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.hit) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_ENT;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_WARN;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign ent_cnt   = cnt_r;

endmodule

[hw/rtl/minute_event_scheduler.sv]
// Minute event scheduler, top level: controller, datapath and divider.
// Depends on mes_pkg, mes_ctrl, mes_dp.
//
// One item at a time. A load or restart item goes from acceptance straight to
// its result. A tick runs two remainders (warning, monitor) on one shared
// restoring divider; the ten-minute retry check is a reciprocal multiply on
// the minute counter. It then scans the schedule table: a skipped entry is
// passed over, a checked one takes up to two more remainders plus a compare.
// The result sits in an output register, so the next item is taken while
// it waits. Configuration writes are always ready and must come while idle.
module minute_event_scheduler
  import mes_pkg::*;
#(
  parameter int SCHEDULE_ENTRIES = 9
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // hour[4:0] minute[10:5] weekday[13:11] clock_valid[14]
  // monitor_retry_pending[15] upload_retry_pending[16] entry_index[20:17]
  // entry_period[28:21] entry_weekday[31:29] entry_minute[43:32], zero fill
  input  logic [47:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // warn_event[0] monitor_event[1] upload_event[2] clear_monitor_retry[3]
  // clear_upload_retry[4] sync_kick[5] day_wrap[6], zero fill
  output logic [7:0]  out_tdata
);

  localparam int IW = (SCHEDULE_ENTRIES > 1) ? $clog2(SCHEDULE_ENTRIES) : 1;
  localparam int CW = $clog2(SCHEDULE_ENTRIES + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [CW-1:0] ent_cnt;

  assign cfg_ready = 1'b1;

  mes_ctrl #(.CW(CW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd),
    .ent_cnt   (ent_cnt)
  );

  mes_dp #(.SCHEDULE_ENTRIES(SCHEDULE_ENTRIES), .IW(IW), .CW(CW)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .ent_cnt    (ent_cnt),
    .out_tready (out_tready),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
